>>> design/ifs_pkg.sv
// Shared types, marker codes and helper functions of the IFS field splitter.
package ifs_pkg;

	// Marker bytes of an expanded word
	localparam logic [7:0] MK_AT_SPLIT  = 8'h01;
	localparam logic [7:0] MK_PREFIX    = 8'h02;
	localparam logic [7:0] MK_EMPTY     = 8'h03;
	localparam logic [7:0] MK_Q_SPACE   = 8'h04;
	localparam logic [7:0] MK_Q_TAB     = 8'h05;
	localparam logic [7:0] MK_Q_NEWLINE = 8'h06;
	localparam logic [7:0] MK_Q_STAR    = 8'h07;
	localparam logic [7:0] MK_Q_QMARK   = 8'h08;
	localparam logic [7:0] MK_Q_LBRACK  = 8'h0E;

	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_STAR    = 8'h2A;
	localparam logic [7:0] CH_QMARK   = 8'h3F;
	localparam logic [7:0] CH_LBRACK  = 8'h5B;

	// Split phase codes
	localparam logic [1:0] PH_START = 2'd0;
	localparam logic [1:0] PH_FIELD = 2'd1;
	localparam logic [1:0] PH_WS    = 2'd2;
	localparam logic [1:0] PH_DELIM = 2'd3;

	// Register map (word index of paddr)
	localparam int unsigned ADDR_W = 5;
	localparam logic [2:0] REG_SPLIT_EN  = 3'd0;
	localparam logic [2:0] REG_IFS_COUNT = 3'd1;
	localparam logic [2:0] REG_IFS_CHAR0 = 3'd2;
	localparam logic [2:0] REG_IFS_CHAR1 = 3'd3;
	localparam logic [2:0] REG_IFS_CHAR2 = 3'd4;
	localparam logic [2:0] REG_IFS_CHAR3 = 3'd5;
	localparam int unsigned NUM_CHAR_REGS = 4;

	typedef struct packed {
		logic       kind;
		logic [7:0] in_char;
	} item_t;

	typedef struct packed {
		logic [1:0] phase;
		logic       esc;
		logic       seen;
	} split_st_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       char_valid;
		logic       field_end;
		logic       done_res;
	} res_t;

	function automatic logic [7:0] restore_char(input logic [7:0] c);
		logic [7:0] r;
		case (c)
			MK_Q_SPACE:   r = CH_SPACE;
			MK_Q_TAB:     r = CH_TAB;
			MK_Q_NEWLINE: r = CH_NEWLINE;
			MK_Q_STAR:    r = CH_STAR;
			MK_Q_QMARK:   r = CH_QMARK;
			MK_Q_LBRACK:  r = CH_LBRACK;
			default:      r = c;
		endcase
		return r;
	endfunction

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NEWLINE);
	endfunction

endpackage

>>> design/ifs_in_if.sv
// Input channel of the splitter: one byte or an end item per transaction.
interface ifs_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] in_char;

	modport source (output valid, output kind, output in_char, input ready);
	modport sink (input valid, input kind, input in_char, output ready);
endinterface

>>> design/ifs_out_if.sv
// Output channel of the splitter: one field byte and flags per transaction.
interface ifs_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       char_valid;
	logic       field_end;
	logic       done_res;
	logic       last_of_run;

	modport source (output valid, output out_char, output char_valid, output field_end,
		output done_res, output last_of_run, input ready);
	modport sink (input valid, input out_char, input char_valid, input field_end,
		input done_res, input last_of_run, output ready);
endinterface

>>> design/ifs_field_splitter_top.sv
// Top level of the IFS field splitter: channels, pipeline and state registers.
//
// Usage:
//   word  - input channel. Each transaction carries one byte of an expanded
//           shell word (kind 0) or the end of the word (kind 1).
//   field - output channel. Each transaction carries at most one restored
//           byte plus a field-end flag; done_res marks the end of the word,
//           last_of_run is set on every transaction since an input item
//           causes at most one result.
//   APB   - register port for split enable, IFS count and IFS characters.
//           Write registers only while the block is idle.
// Timing: one item per clock sustained while field.ready stays high. An
// accepted item is held in the input stage, decoded combinationally and its
// result is loaded into the result register that drives field. The
// throughput is set by the state update in the decode stage, which reads and
// writes the split state once per item. Items that cause no result (a literal
// prefix, collapsed whitespace) retire without an output transaction.
// Reset: clears the input and output stages and the split state; registers
// return to split on, three characters: space, tab and newline.
// Stall: when field.ready is low the result register holds, the input stage
// fills and then word.ready drops; nothing is lost or repeated.
module ifs_field_splitter_top
	import ifs_pkg::*;
#(
	parameter int unsigned IFS_CHARS = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	ifs_in_if.sink            word,
	ifs_out_if.source         field
);

	logic                 split_active;
	logic [7:0]           ifs_char [IFS_CHARS];
	logic [IFS_CHARS-1:0] ifs_vld;

	item_t     item_s1;
	logic      vld_s1;
	split_st_t st_q;
	split_st_t st_nxt;
	res_t      res;
	logic      res_ok;
	res_t      res_s2;
	logic      vld_s2;
	logic      out_free;
	logic      adv;
	logic      take;

	ifs_cfg #(
		.IFS_CHARS(IFS_CHARS)
	) u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.split_active (split_active),
		.ifs_char     (ifs_char),
		.ifs_vld      (ifs_vld)
	);

	ifs_core #(
		.IFS_CHARS(IFS_CHARS)
	) u_core (
		.item         (item_s1),
		.st           (st_q),
		.split_active (split_active),
		.ifs_char     (ifs_char),
		.ifs_vld      (ifs_vld),
		.st_nxt       (st_nxt),
		.res          (res),
		.res_ok       (res_ok)
	);

	// Advance the decode stage whenever the result register can take a value
	assign out_free   = !vld_s2 || field.ready;
	assign adv        = vld_s1 && out_free;
	assign word.ready = !vld_s1 || adv;
	assign take       = word.valid && word.ready;

	// Input stage: hold the accepted transaction until it is decoded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= '{kind: word.kind, in_char: word.in_char};
		end
	end

	// Split state: advance once per decoded item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (adv) begin
			st_q <= st_nxt;
		end
	end

	// Result register: load a result, drop it once the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv && res_ok) begin
			vld_s2 <= 1'b1;
		end else if (field.ready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_ok) begin
			res_s2 <= res;
		end
	end

	assign field.valid       = vld_s2;
	assign field.out_char    = res_s2.out_char;
	assign field.char_valid  = res_s2.char_valid;
	assign field.field_end   = res_s2.field_end;
	assign field.done_res    = res_s2.done_res;
	assign field.last_of_run = 1'b1;

`ifndef SYNTHESIS
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && item_s1.kind |=> st_q == '0)
		else $error("split state not cleared after end of word");

	a_esc_seen: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.esc |-> st_q.seen)
		else $error("pending prefix in a piece marked empty");

	a_no_blank: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> (res_s2.char_valid || res_s2.field_end || res_s2.done_res))
		else $error("result transaction carries nothing");

	a_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && !res_s2.char_valid |-> res_s2.out_char == 8'h00)
		else $error("stray byte on a result without a character");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !adv |=> vld_s1 && $stable(item_s1))
		else $error("stalled input stage lost its item");
`endif

endmodule

>>> design/ifs_cfg.sv
// APB register bank holding split enable, IFS count and IFS characters.
module ifs_cfg
	import ifs_pkg::*;
#(
	parameter int unsigned IFS_CHARS = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_W-1:0]    paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	output logic                 split_active,
	output logic [7:0]           ifs_char [IFS_CHARS],
	output logic [IFS_CHARS-1:0] ifs_vld
);

	logic                 en_q;
	logic [2:0]           cnt_q;
	logic [7:0]           chr_q [IFS_CHARS];
	logic [7:0]           chr_rd [NUM_CHAR_REGS];
	logic [2:0]           idx;
	logic                 wr;
	logic [3:0]           cnt_eff;
	logic [IFS_CHARS-1:0] nz;

	assign pready = 1'b1;
	assign idx    = paddr[ADDR_W-1:2];
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q  <= 1'b1;
			cnt_q <= 3'd3;
		end else if (wr) begin
			if (idx == REG_SPLIT_EN) begin
				en_q <= pwdata[0];
			end
			if (idx == REG_IFS_COUNT) begin
				cnt_q <= pwdata[2:0];
			end
		end
	end

	for (genvar i = 0; i < IFS_CHARS; i++) begin : g_chr
		localparam logic [7:0] RST = (i == 0) ? CH_SPACE :
			(i == 1) ? CH_TAB : (i == 2) ? CH_NEWLINE : 8'h00;
		if (i < NUM_CHAR_REGS) begin : g_wr
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					chr_q[i] <= RST;
				end else if (wr && idx == REG_IFS_CHAR0 + 3'(i)) begin
					chr_q[i] <= pwdata[7:0];
				end
			end
		end else begin : g_const
			// no register reaches this slot: it keeps its reset value
			assign chr_q[i] = RST;
		end
		assign ifs_char[i] = chr_q[i];
		assign ifs_vld[i]  = 4'(i) < cnt_eff;
		assign nz[i]       = chr_q[i] != 8'h00;
	end

	for (genvar k = 0; k < NUM_CHAR_REGS; k++) begin : g_rd
		if (k < IFS_CHARS) begin : g_have
			assign chr_rd[k] = chr_q[k];
		end else begin : g_none
			assign chr_rd[k] = 8'h00;
		end
	end

	// clamp an oversized count to the number of slots
	assign cnt_eff      = ({1'b0, cnt_q} > 4'(IFS_CHARS)) ? 4'(IFS_CHARS) : {1'b0, cnt_q};
	assign split_active = en_q && |(ifs_vld & nz);

	always_comb begin
		case (idx)
			REG_SPLIT_EN:  prdata = {31'b0, en_q};
			REG_IFS_COUNT: prdata = {29'b0, cnt_q};
			REG_IFS_CHAR0: prdata = {24'b0, chr_rd[0]};
			REG_IFS_CHAR1: prdata = {24'b0, chr_rd[1]};
			REG_IFS_CHAR2: prdata = {24'b0, chr_rd[2]};
			REG_IFS_CHAR3: prdata = {24'b0, chr_rd[3]};
			default:       prdata = 32'b0;
		endcase
	end

endmodule

>>> design/ifs_core.sv
// Per-item decision logic: next split state and the result of one item.
module ifs_core
	import ifs_pkg::*;
#(
	parameter int unsigned IFS_CHARS = 4
) (
	input  item_t                item,
	input  split_st_t            st,
	input  logic                 split_active,
	input  logic [7:0]           ifs_char [IFS_CHARS],
	input  logic [IFS_CHARS-1:0] ifs_vld,
	output split_st_t            st_nxt,
	output res_t                 res,
	output logic                 res_ok
);

	logic [7:0]           c;
	logic [7:0]           tb;
	logic                 brk;
	logic [IFS_CHARS-1:0] hit;
	logic                 delim;
	logic                 ws;

	assign c   = item.in_char;
	assign brk = item.kind || (c == MK_AT_SPLIT);
	// at a piece break only a dangling prefix is tested
	assign tb  = brk ? MK_PREFIX : c;
	assign ws  = is_ws(tb);

	always_comb begin
		for (int i = 0; i < IFS_CHARS; i++) begin
			hit[i] = ifs_vld[i] && (ifs_char[i] == tb);
		end
	end

	always_comb begin
		delim = split_active && |hit && (tb != 8'h00);
		if (tb inside {MK_Q_SPACE, MK_Q_TAB, MK_Q_NEWLINE}) begin
			delim = 1'b0;
		end
	end

	always_comb begin
		st_nxt = st;
		res    = '0;
		res_ok = 1'b0;
		if (brk) begin
			if (st.esc) begin
				if (delim) begin
					res.field_end = (st.phase != PH_WS);
				end else begin
					res.out_char   = MK_PREFIX;
					res.char_valid = 1'b1;
					res.field_end  = 1'b1;
				end
			end else begin
				res.field_end = (st.phase == PH_FIELD) || (st.phase == PH_START && !st.seen);
			end
			res.done_res = item.kind;
			res_ok       = res.field_end || res.char_valid || item.kind;
			st_nxt       = '0;
		end else if (st.esc) begin
			st_nxt.esc     = 1'b0;
			st_nxt.seen    = 1'b1;
			st_nxt.phase   = PH_FIELD;
			res.out_char   = c;
			res.char_valid = 1'b1;
			res_ok         = 1'b1;
		end else if (c == MK_PREFIX) begin
			st_nxt.esc  = 1'b1;
			st_nxt.seen = 1'b1;
		end else begin
			st_nxt.seen = 1'b1;
			if (delim) begin
				case (st.phase)
					PH_FIELD: begin
						res.field_end = 1'b1;
						st_nxt.phase  = ws ? PH_WS : PH_DELIM;
					end
					PH_START: begin
						if (!ws) begin
							res.field_end = 1'b1;
							st_nxt.phase  = PH_DELIM;
						end
					end
					PH_WS: begin
						if (!ws) begin
							st_nxt.phase = PH_DELIM;
						end
					end
					default: begin
						res.field_end = !ws;
					end
				endcase
				res_ok = res.field_end;
			end else begin
				st_nxt.phase = PH_FIELD;
				if (c != MK_EMPTY) begin
					res.out_char   = restore_char(c);
					res.char_valid = 1'b1;
					res_ok         = 1'b1;
				end
			end
		end
	end

endmodule
